### src/max_flow_bfs_augment_macros.svh
// ----------------------------------------------------------------------------
// Max-flow BFS augment: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef MAX_FLOW_BFS_AUGMENT_MACROS_SVH
`define MAX_FLOW_BFS_AUGMENT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define MFBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also checks through reset
`define MFBA_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### src/mfba_pkg.sv
// ----------------------------------------------------------------------------
// Max-flow BFS augment package
// Shared types and constants for the max-flow engine.
// ----------------------------------------------------------------------------
package mfba_pkg;

    // result width and saturation value of the flow total
    localparam int FLOW_W = 22;
    localparam logic [FLOW_W-1:0] FLOW_MAX = 22'h3F_FFFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK_NODE   = 2'd2;

    // status of the capacity store toward the controller
    typedef struct packed {
        logic clearing;    // post-reset clearing pass running
        logic ld_pending;  // an edge update is still in its write stage
    } t_cap_status;

endpackage

### src/mfba_cap_store.sv
// ----------------------------------------------------------------------------
// Capacity store
// Capacity matrix memory with post-reset clearing pass and a two-stage
// read-add-write path for edge loads, forwarding back-to-back updates.
// ----------------------------------------------------------------------------
module mfba_cap_store #(
    parameter int ADDR_W   = 12,
    parameter int CAP_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ld_en,
    input  logic [ADDR_W-1:0]     i_addr,
    input  logic [CAP_BITS-1:0]   i_ld_add,
    output logic [CAP_BITS-1:0]   o_rd_data,
    output mfba_pkg::t_cap_status o_status
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [CAP_BITS-1:0] r_mem [DEPTH];
    logic [CAP_BITS-1:0] r_rd_data;

    logic                r_clearing;
    logic [ADDR_W-1:0]   r_clr_cnt;

    logic                r_st_valid;
    logic [ADDR_W-1:0]   r_st_addr;
    logic [CAP_BITS-1:0] r_st_add;

    logic                r_fw_valid;
    logic [ADDR_W-1:0]   r_fw_addr;
    logic [CAP_BITS-1:0] r_fw_data;

    logic [CAP_BITS-1:0] w_old;
    logic [CAP_BITS:0]   w_sum;
    logic [CAP_BITS-1:0] w_sat;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [CAP_BITS-1:0] w_wdata;

    // saturating add, with the word written last edge forwarded
    always_comb begin
        w_old   = (r_fw_valid && (r_fw_addr == r_st_addr)) ? r_fw_data : r_rd_data;
        w_sum   = {1'b0, w_old} + {1'b0, r_st_add};
        w_sat   = w_sum[CAP_BITS] ? {CAP_BITS{1'b1}} : w_sum[CAP_BITS-1:0];
        w_we    = r_clearing || r_st_valid;
        w_waddr = r_clearing ? r_clr_cnt : r_st_addr;
        w_wdata = r_clearing ? '0 : w_sat;
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[i_addr];
    end

    // clearing pass and update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_st_valid <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == {ADDR_W{1'b1}}) begin
                    r_clearing <= 1'b0;
                end
            end
            r_st_valid <= i_ld_en;
            r_fw_valid <= r_st_valid;
        end
    end

    // update stage payload
    always_ff @(posedge i_clk) begin
        r_st_addr <= i_addr;
        r_st_add  <= i_ld_add;
        r_fw_addr <= r_st_addr;
        r_fw_data <= w_sat;
    end

    assign o_rd_data           = r_rd_data;
    assign o_status.clearing   = r_clearing;
    assign o_status.ld_pending = r_st_valid;

endmodule

### src/max_flow_bfs_augment.sv
// ----------------------------------------------------------------------------
// Max-flow BFS augment (Edmonds-Karp)
// Loads edges into a capacity matrix and computes source-to-sink maximum
// flow by repeated breadth-first search and path augmentation.
// ----------------------------------------------------------------------------
//  channel   handshake                   word
//  ------    --------------------------  ----------------------------------
//  input     i_in_valid / o_in_ready     mode, from_node, to_node, capacity
//  output    o_out_valid / i_out_ready   flow total (one per compute word)
//  config    i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  Edge loads: one per cycle while the sequencer is idle, through the capacity
//  store read-add-write path. Compute: copy of N*N entries (N =
//  2**clog2(MAX_NODES)), then per search a row scan per dequeued node and the
//  bottleneck and augment walks; trivial cases skip to the result. After reset
//  a clearing pass over N*N entries runs with o_in_ready low. A finished
//  result waits in the output register; loads continue meanwhile.
// ----------------------------------------------------------------------------
module max_flow_bfs_augment #(
    parameter int MAX_NODES = 64,
    parameter int CAP_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mfba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [$clog2(MAX_NODES):0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic [$clog2(MAX_NODES)-1:0]   i_from_node,
    input  logic [$clog2(MAX_NODES)-1:0]   i_to_node,
    input  logic [CAP_BITS-1:0]            i_edge_capacity,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mfba_pkg::FLOW_W-1:0]    o_flow_total
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = NODE_W + 1;
    localparam int ADDR_W = 2 * NODE_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int RES_W  = CAP_BITS + 1;
    localparam int FLOW_W = mfba_pkg::FLOW_W;
    localparam int SUM_W  = ((RES_W > FLOW_W) ? RES_W : FLOW_W) + 1;

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_COPY     = 14'h0002,
        S_BFS_INIT = 14'h0004,
        S_POP      = 14'h0008,
        S_HEAD     = 14'h0010,
        S_ROW      = 14'h0020,
        S_PM_PAR   = 14'h0040,
        S_PM_RD    = 14'h0080,
        S_PM_CMP   = 14'h0100,
        S_AU_PAR   = 14'h0200,
        S_AU_FRD   = 14'h0400,
        S_AU_FWR   = 14'h0800,
        S_AU_RWR   = 14'h1000,
        S_DONE     = 14'h2000
    } t_state;

    t_state r_state;

    // configuration
    logic [CNT_W-1:0]  r_node_count;
    logic [NODE_W-1:0] r_source;
    logic [NODE_W-1:0] r_sink;

    // search state
    logic [MAX_NODES-1:0] r_vis;
    logic [CNT_W-1:0]     r_head;
    logic [CNT_W-1:0]     r_tail;
    logic [NODE_W-1:0]    r_u;
    logic [CNT_W-1:0]     r_iv;
    logic                 r_chk_valid;
    logic [NODE_W-1:0]    r_chk_v;
    logic [NODE_W-1:0]    r_v;
    logic [NODE_W-1:0]    r_p;
    logic [RES_W-1:0]     r_path;
    logic [FLOW_W-1:0]    r_total;

    // copy sweep
    logic [ADDR_W-1:0]    r_cp_cnt;
    logic                 r_cp_wv;
    logic [ADDR_W-1:0]    r_cp_waddr;

    // output register
    logic                 r_out_valid;
    logic [FLOW_W-1:0]    r_out_data;

    // memories
    logic [RES_W-1:0]     r_res [DEPTH];
    logic [RES_W-1:0]     r_res_rd;
    logic [NODE_W-1:0]    r_par [MAX_NODES];
    logic [NODE_W-1:0]    r_par_rd;
    logic [NODE_W-1:0]    r_que [MAX_NODES];
    logic [NODE_W-1:0]    r_que_rd;

    // capacity store link
    logic [CAP_BITS-1:0]   w_cap_rd;
    mfba_pkg::t_cap_status w_cap_st;
    logic                  w_ld_en;
    logic [ADDR_W-1:0]     w_cap_addr;

    logic [CNT_W-1:0]     w_n;
    logic                 w_in_acc;
    logic                 w_edge_ok;
    logic                 w_trivial;
    logic                 w_hit;
    logic [RES_W-1:0]     w_min;
    logic [SUM_W-1:0]     w_sum;
    logic [FLOW_W-1:0]    w_sum_sat;

    logic                 w_res_we;
    logic [ADDR_W-1:0]    w_res_waddr;
    logic [RES_W-1:0]     w_res_wdata;
    logic [ADDR_W-1:0]    w_res_raddr;
    logic                 w_par_we;
    logic [NODE_W-1:0]    w_par_waddr;
    logic [NODE_W-1:0]    w_par_wdata;
    logic                 w_que_we;
    logic [NODE_W-1:0]    w_que_waddr;
    logic [NODE_W-1:0]    w_que_wdata;

    // effective node count and input handshake
    always_comb begin
        w_n = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
        o_in_ready = (r_state == S_IDLE) && !w_cap_st.clearing
                     && (!i_mode || (!r_out_valid && !w_cap_st.ld_pending));
        w_in_acc  = i_in_valid && o_in_ready;
        w_edge_ok = ({1'b0, i_from_node} < w_n) && ({1'b0, i_to_node} < w_n);
        w_ld_en   = w_in_acc && !i_mode && w_edge_ok;
        w_cap_addr = (r_state == S_COPY) ? r_cp_cnt : {i_from_node, i_to_node};
        w_trivial = (w_n < CNT_W'(2)) || ({1'b0, r_source} >= w_n)
                    || ({1'b0, r_sink} >= w_n) || (r_source == r_sink);
    end

    // neighbor test, path minimum and flow saturation
    always_comb begin
        w_hit = r_chk_valid && !r_vis[r_chk_v] && (r_res_rd != '0);
        w_min = (r_res_rd < r_path) ? r_res_rd : r_path;
        w_sum = SUM_W'(r_total) + SUM_W'(w_min);
        w_sum_sat = (w_sum > SUM_W'(mfba_pkg::FLOW_MAX)) ? mfba_pkg::FLOW_MAX
                                                       : w_sum[FLOW_W-1:0];
    end

    // residual memory ports
    always_comb begin
        w_res_we    = 1'b0;
        w_res_waddr = {r_p, r_v};
        w_res_wdata = r_res_rd - r_path;
        if (r_cp_wv) begin
            w_res_we    = 1'b1;
            w_res_waddr = r_cp_waddr;
            w_res_wdata = {1'b0, w_cap_rd};
        end else if (r_state == S_AU_FWR) begin
            w_res_we    = 1'b1;
        end else if (r_state == S_AU_RWR) begin
            w_res_we    = 1'b1;
            w_res_waddr = {r_v, r_p};
            w_res_wdata = r_res_rd + r_path;
        end
        case (r_state)
            S_PM_RD, S_AU_FRD: w_res_raddr = {r_par_rd, r_v};
            S_AU_FWR:          w_res_raddr = {r_v, r_p};
            default:           w_res_raddr = {r_u, r_iv[NODE_W-1:0]};
        endcase
    end

    // parent and queue memory ports
    always_comb begin
        w_par_we    = 1'b0;
        w_par_waddr = r_chk_v;
        w_par_wdata = r_u;
        w_que_we    = 1'b0;
        w_que_waddr = r_tail[NODE_W-1:0];
        w_que_wdata = r_chk_v;
        if (r_state == S_BFS_INIT) begin
            w_par_we    = 1'b1;
            w_par_waddr = r_source;
            w_par_wdata = r_source;
            w_que_we    = 1'b1;
            w_que_waddr = '0;
            w_que_wdata = r_source;
        end else if (w_hit) begin
            w_par_we = 1'b1;
            w_que_we = (r_tail < CNT_W'(MAX_NODES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_we) begin
            r_res[w_res_waddr] <= w_res_wdata;
        end
        r_res_rd <= r_res[w_res_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_par_we) begin
            r_par[w_par_waddr] <= w_par_wdata;
        end
        r_par_rd <= r_par[r_v];
    end

    always_ff @(posedge i_clk) begin
        if (w_que_we) begin
            r_que[w_que_waddr] <= w_que_wdata;
        end
        r_que_rd <= r_que[r_head[NODE_W-1:0]];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(MAX_NODES);
            r_source     <= '0;
            r_sink       <= NODE_W'(MAX_NODES - 1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mfba_pkg::CFG_NODE_COUNT:  r_node_count <= i_cfg_data;
                mfba_pkg::CFG_SOURCE_NODE: r_source     <= i_cfg_data[NODE_W-1:0];
                mfba_pkg::CFG_SINK_NODE:   r_sink       <= i_cfg_data[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vis       <= '0;
            r_chk_valid <= 1'b0;
            r_cp_wv     <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            r_cp_wv    <= (r_state == S_COPY);
            r_cp_waddr <= r_cp_cnt;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // record new neighbors during the row scan
            if (w_hit) begin
                r_vis[r_chk_v] <= 1'b1;
                r_tail         <= r_tail + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_mode) begin
                        r_total  <= '0;
                        r_cp_cnt <= '0;
                        r_state  <= w_trivial ? S_DONE : S_COPY;
                    end
                end
                S_COPY: begin
                    r_cp_cnt <= r_cp_cnt + 1'b1;
                    if (r_cp_cnt == {ADDR_W{1'b1}}) begin
                        r_state <= S_BFS_INIT;
                    end
                end
                S_BFS_INIT: begin
                    r_vis   <= MAX_NODES'(1) << r_source;
                    r_head  <= '0;
                    r_tail  <= CNT_W'(1);
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_head == r_tail) begin
                        r_v     <= r_sink;
                        r_path  <= {RES_W{1'b1}};
                        r_state <= r_vis[r_sink] ? S_PM_PAR : S_DONE;
                    end else begin
                        r_head  <= r_head + 1'b1;
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_u         <= r_que_rd;
                    r_iv        <= '0;
                    r_chk_valid <= 1'b0;
                    r_state     <= S_ROW;
                end
                S_ROW: begin
                    if (r_iv < w_n) begin
                        r_iv        <= r_iv + 1'b1;
                        r_chk_valid <= 1'b1;
                        r_chk_v     <= r_iv[NODE_W-1:0];
                    end else begin
                        r_chk_valid <= 1'b0;
                        if (!r_chk_valid) begin
                            r_state <= S_POP;
                        end
                    end
                end
                // walk back from the sink for the bottleneck
                S_PM_PAR: r_state <= S_PM_RD;
                S_PM_RD: begin
                    r_p     <= r_par_rd;
                    r_state <= S_PM_CMP;
                end
                S_PM_CMP: begin
                    r_path <= w_min;
                    if (r_p == r_source) begin
                        r_total <= w_sum_sat;
                        r_v     <= r_sink;
                        r_state <= S_AU_PAR;
                    end else begin
                        r_v     <= r_p;
                        r_state <= S_PM_PAR;
                    end
                end
                // second walk adjusts forward and reverse residuals
                S_AU_PAR: r_state <= S_AU_FRD;
                S_AU_FRD: begin
                    r_p     <= r_par_rd;
                    r_state <= S_AU_FWR;
                end
                S_AU_FWR: r_state <= S_AU_RWR;
                S_AU_RWR: begin
                    r_v     <= r_p;
                    r_state <= (r_p == r_source) ? S_BFS_INIT : S_AU_PAR;
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= r_total;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mfba_cap_store #(
        .ADDR_W   (ADDR_W),
        .CAP_BITS (CAP_BITS)
    ) u_cap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ld_en   (w_ld_en),
        .i_addr    (w_cap_addr),
        .i_ld_add  (i_edge_capacity),
        .o_rd_data (w_cap_rd),
        .o_status  (w_cap_st)
    );

    assign o_out_valid  = r_out_valid;
    assign o_flow_total = r_out_data;

endmodule

### src/mfba_checker.sv
// ----------------------------------------------------------------------------
// Max-flow BFS augment checker
// Port-level assertions on handshakes, result ordering and reset.
// ----------------------------------------------------------------------------
`include "max_flow_bfs_augment_macros.svh"

module mfba_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_mode,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [mfba_pkg::FLOW_W-1:0] i_flow_total
);

    // a stalled result word holds
    `MFBA_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_flow_total), "result word changed while stalled")

    // a compute word never sees its result in the next cycle
    `MFBA_ASSERT(a_cmp_lat, i_clk, i_rst_n, i_in_valid && i_in_ready && i_mode |=> !i_out_valid, "result too early after compute word")

    // no compute word is taken while a result waits
    `MFBA_ASSERT(a_cmp_block, i_clk, i_rst_n, i_out_valid |-> !(i_in_valid && i_in_ready && i_mode), "compute word taken while result pending")

    // reset empties the output and holds off input
    `MFBA_ASSERT_RST(a_reset, i_clk, !i_rst_n |=> !i_out_valid && !i_in_ready, "not quiet after reset")

endmodule

bind max_flow_bfs_augment mfba_checker u_mfba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_ready   (o_in_ready),
    .i_mode       (i_mode),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_flow_total (o_flow_total)
);

### test/max_flow_bfs_augment_tb.sv
// ----------------------------------------------------------------------------
// Max-flow BFS augment testbench
// Loads random and hand-picked graphs, asks for the maximum flow under many
// node counts and source/sink settings, and checks every flow word against
// an in-bench Edmonds-Karp predictor. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module max_flow_bfs_augment_tb;

    localparam int  NODES      = 64;
    localparam int  CAP_W      = 16;
    localparam int  FLOW_W     = mfba_pkg::FLOW_W;
    localparam int  IDLE_GAP   = 16;       // load write stage settle time
    localparam int  WDOG_LIMIT = 2000000;  // cycles with no word moving
    localparam int  HOLD_LEN   = 12000;    // long receiver hold-off
    localparam bit  MODE_LOAD  = 1'b0;
    localparam bit  MODE_FLOW  = 1'b1;
    localparam int  ITEM_GOAL  = 1950;

    typedef struct {
        bit              mode;
        bit [5:0]        from_n;
        bit [5:0]        to_n;
        bit [CAP_W-1:0]  cap;
    } t_word;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [mfba_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [6:0]                      i_cfg_data;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic                            i_mode = MODE_LOAD;
    logic [5:0]                      i_from_node = '0;
    logic [5:0]                      i_to_node = '0;
    logic [CAP_W-1:0]                i_edge_capacity = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [FLOW_W-1:0]               o_flow_total;

    max_flow_bfs_augment uut (.*);

    // predictor state
    bit [CAP_W-1:0]  cap_mat [NODES*NODES];
    int unsigned     cfg_nodes = 64;
    int unsigned     cfg_src   = 0;
    int unsigned     cfg_sink  = 63;

    t_word           word_q [$];
    bit [FLOW_W-1:0] flow_q [$];
    int              err_cnt = 0;
    int              item_cnt = 0;
    int              wdog = 0;
    bit              in_fire = 0;
    bit              hold_req = 0;

    // Edmonds-Karp over a local residual copy, neighbors in ascending order
    function automatic bit [FLOW_W-1:0] predict_flow();
        int unsigned n;
        longint      res [NODES*NODES];
        int unsigned par [NODES];
        int unsigned bfs_q [NODES];
        bit          seen [NODES];
        int unsigned head, tail, u, v;
        longint      path, total;
        n = (cfg_nodes > NODES) ? NODES : cfg_nodes;
        total = 0;
        if (n < 2 || cfg_src >= n || cfg_sink >= n || cfg_src == cfg_sink)
            return '0;
        foreach (res[k]) res[k] = cap_mat[k];
        forever begin
            foreach (seen[k]) seen[k] = 0;
            head = 0; tail = 0;
            seen[cfg_src] = 1;
            par[cfg_src] = cfg_src;
            bfs_q[tail++] = cfg_src;
            while (head < tail) begin
                u = bfs_q[head++];
                for (v = 0; v < n; v++) begin
                    if (!seen[v] && res[u*NODES+v] > 0) begin
                        seen[v] = 1;
                        par[v] = u;
                        if (tail < NODES) bfs_q[tail++] = v;
                    end
                end
            end
            if (!seen[cfg_sink]) break;
            path = 64'h7FFF_FFFF_FFFF_FFFF;
            for (v = cfg_sink; v != cfg_src; v = u) begin
                u = par[v];
                if (res[u*NODES+v] < path) path = res[u*NODES+v];
            end
            for (v = cfg_sink; v != cfg_src; v = u) begin
                u = par[v];
                res[u*NODES+v] -= path;
                res[v*NODES+u] += path;
            end
            total += path;
            if (total > mfba_pkg::FLOW_MAX) total = mfba_pkg::FLOW_MAX;
        end
        return total[FLOW_W-1:0];
    endfunction

    // clock and reset
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // input driver: bursts with random gaps
    int burst_left = 4;
    int gap_left   = 0;
    always @(negedge i_clk) begin
        t_word w;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (word_q.size() > 0) begin
                w = word_q.pop_front();
                i_in_valid      <= 1'b1;
                i_mode          <= w.mode;
                i_from_node     <= w.from_n;
                i_to_node       <= w.to_n;
                i_edge_capacity <= w.cap;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    int rx_mode = 0;
    int rx_cnt  = 0;
    int hold_cnt = 0;
    always @(negedge i_clk) begin
        if (hold_req && hold_cnt == 0) begin
            hold_cnt = HOLD_LEN;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            rx_cnt++;
            if (rx_cnt % 200 == 0) rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= (rx_cnt % 4 == 0);
            endcase
        end
    end

    // monitor: predict on input acceptance, check flow words, watchdog
    always @(posedge i_clk) begin
        int unsigned n, idx;
        int unsigned sum;
        bit [FLOW_W-1:0] want;
        n = (cfg_nodes > NODES) ? NODES : cfg_nodes;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            wdog = 0;
        else
            wdog++;
        if (wdog >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (i_mode == MODE_FLOW) begin
                flow_q.insert(flow_q.size(), predict_flow());
            end else if (i_from_node < n && i_to_node < n) begin
                idx = i_from_node * NODES + i_to_node;
                sum = cap_mat[idx] + i_edge_capacity;
                cap_mat[idx] = (sum > 16'hFFFF) ? 16'hFFFF : sum[CAP_W-1:0];
            end
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (flow_q.size() == 0) begin
                $display("%0t: unexpected flow word, actual %0d", $realtime, o_flow_total);
                err_cnt++;
            end else begin
                want = flow_q.pop_front();
                if (o_flow_total !== want) begin
                    $display("%0t: flow mismatch, expected %0d actual %0d",
                             $realtime, want, o_flow_total);
                    err_cnt++;
                end
            end
        end
    end

    task automatic push_load(input int unsigned f, input int unsigned t, input int unsigned c);
        t_word w;
        w.mode = MODE_LOAD; w.from_n = 6'(f); w.to_n = 6'(t); w.cap = CAP_W'(c);
        word_q.insert(word_q.size(), w);
        item_cnt++;
    endtask

    task automatic push_flow();
        t_word w;
        w.mode = MODE_FLOW;
        w.from_n = 6'($urandom); w.to_n = 6'($urandom); w.cap = CAP_W'($urandom);
        word_q.insert(word_q.size(), w);
        item_cnt++;
    endtask

    // wait until nothing is pending, then let a load write stage finish
    task automatic wait_idle();
        while (word_q.size() > 0 || i_in_valid || flow_q.size() > 0)
            @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_cfg(input int unsigned nodes, input int unsigned src,
                             input int unsigned sink);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= mfba_pkg::CFG_NODE_COUNT; i_cfg_data <= 7'(nodes);
        cfg_nodes = nodes & 7'h7F;
        @(negedge i_clk);
        i_cfg_idx <= mfba_pkg::CFG_SOURCE_NODE; i_cfg_data <= 7'(src);
        cfg_src = src & 6'h3F;
        @(negedge i_clk);
        i_cfg_idx <= mfba_pkg::CFG_SINK_NODE; i_cfg_data <= 7'(sink);
        cfg_sink = sink & 6'h3F;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int unsigned rand_cap();
        case ($urandom_range(0, 5))
            0:       return 16'hFFFF;
            1, 2:    return $urandom_range(0, 65535);
            default: return $urandom_range(1, 100);
        endcase
    endfunction

    // stimulus sequence
    initial begin
        int unsigned n, nn, src, sink, len, lim;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = mfba_pkg::CFG_NODE_COUNT; i_cfg_data = 0;
        foreach (cap_mat[k]) cap_mat[k] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty graph at reset settings
        push_flow();
        wait_idle();

        // small graph: saturation, self loop, out-of-range endpoints
        write_cfg(8, 0, 7);
        push_load(0, 1, 16'hFFFF);
        push_load(0, 1, 16'hFFFF);
        push_load(1, 7, 16'h8000);
        push_load(0, 2, 16'h0001);
        push_load(2, 7, 16'h7FFF);
        push_load(3, 3, 5);
        push_load(9, 1, 40);
        push_load(1, 63, 40);
        push_load(63, 63, 0);
        push_load(2, 1, 0);
        push_flow();
        wait_idle();
        write_cfg(8, 4, 4);         // source equals sink
        push_flow();
        wait_idle();
        write_cfg(8, 10, 7);        // source beyond node count
        push_flow();
        wait_idle();
        write_cfg(1, 0, 0);         // too few nodes
        push_flow();
        wait_idle();
        write_cfg(0, 0, 1);
        push_flow();
        wait_idle();
        write_cfg(127, 0, 63);      // node count clamps to the maximum
        push_load(62, 63, 16'hFFFF);
        push_load(0, 62, 16'h2A);
        push_load(0, 63, 16'hFFFF);
        push_flow();
        wait_idle();

        // output held off while the input keeps going: block must back up
        write_cfg(8, 0, 7);
        push_flow();
        hold_req = 1;
        for (int k = 0; k < 40; k++) push_load($urandom_range(0, 7), $urandom_range(0, 7),
                                               rand_cap());
        push_flow();
        push_load(5, 6, 7);
        push_flow();
        wait_idle();

        // random phases
        while (item_cnt < ITEM_GOAL) begin
            case ($urandom_range(0, 19))
                0:       nn = 64;
                1:       nn = $urandom_range(65, 127);
                2:       nn = $urandom_range(0, 1);
                3:       nn = 2;
                default: nn = $urandom_range(3, 14);
            endcase
            n = (nn > NODES) ? NODES : nn;
            lim = (n < 2) ? 2 : n;
            src  = $urandom_range(0, lim - 1);
            sink = $urandom_range(0, lim - 1);
            if ($urandom_range(0, 1)) begin
                src = 0; sink = lim - 1;
            end
            if ($urandom_range(0, 15) == 0) sink = $urandom_range(0, 63);
            write_cfg(nn, src, sink);
            len = (n >= 32) ? $urandom_range(3, 12) : $urandom_range(5, 40);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    push_load($urandom_range(0, 63), $urandom_range(0, 63), rand_cap());
                else if (n >= 32 && $urandom_range(0, 1))
                    push_load($urandom_range(0, 63), sink, rand_cap());
                else if (n >= 2)
                    push_load($urandom_range(0, (n > 14 ? 14 : n) - 1),
                              $urandom_range(0, (n > 14 ? 14 : n) - 1), rand_cap());
                else
                    push_load($urandom_range(0, 63), $urandom_range(0, 63), rand_cap());
            end
            push_flow();
            if ($urandom_range(0, 3) == 0) push_flow();
            wait_idle();
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
